>>> rtl/core/g3_fax_line_encoder_assert.svh
// assertion macros for the fax line encoder checker
`ifndef G3_FAX_LINE_ENCODER_ASSERT_SVH
`define G3_FAX_LINE_ENCODER_ASSERT_SVH

// same-cycle implication
`define G3F_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("g3fax check failed");

// next-cycle implication
`define G3F_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("g3fax check failed");

`endif

>>> rtl/core/g3fax_pkg.sv
package g3fax_pkg;

  localparam int LEN_W = 11;
  localparam int QDEPTH = 4;
  localparam logic [2:0] DOC_EOLS = 3'd6;

  localparam logic REG_DARK_THRESHOLD = 1'b0;
  localparam logic REG_LINE_WIDTH = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       doc_done;
  } out_word_t;

  typedef enum logic [1:0] {
    J_RUN,
    J_EOL,
    J_FLUSH
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [LEN_W-1:0] len;
    logic             black;
    logic             first;
    logic             eoi;
    logic             doc;
  } job_t;

  // {length, code}
  typedef logic [16:0] mh_code_t;

  localparam mh_code_t EOL_CODE = {4'd12, 13'h001};

  localparam mh_code_t WHITE_TERM [0:63] = '{
    {4'd8,13'h35},{4'd6,13'h07},{4'd4,13'h7},{4'd4,13'h8},
    {4'd4,13'hB},{4'd4,13'hC},{4'd4,13'hE},{4'd4,13'hF},
    {4'd5,13'h13},{4'd5,13'h14},{4'd5,13'h07},{4'd5,13'h08},
    {4'd6,13'h08},{4'd6,13'h03},{4'd6,13'h34},{4'd6,13'h35},
    {4'd6,13'h2A},{4'd6,13'h2B},{4'd7,13'h27},{4'd7,13'h0C},
    {4'd7,13'h08},{4'd7,13'h17},{4'd7,13'h03},{4'd7,13'h04},
    {4'd7,13'h28},{4'd7,13'h2B},{4'd7,13'h13},{4'd7,13'h24},
    {4'd7,13'h18},{4'd8,13'h02},{4'd8,13'h03},{4'd8,13'h1A},
    {4'd8,13'h1B},{4'd8,13'h12},{4'd8,13'h13},{4'd8,13'h14},
    {4'd8,13'h15},{4'd8,13'h16},{4'd8,13'h17},{4'd8,13'h28},
    {4'd8,13'h29},{4'd8,13'h2A},{4'd8,13'h2B},{4'd8,13'h2C},
    {4'd8,13'h2D},{4'd8,13'h04},{4'd8,13'h05},{4'd8,13'h0A},
    {4'd8,13'h0B},{4'd8,13'h52},{4'd8,13'h53},{4'd8,13'h54},
    {4'd8,13'h55},{4'd8,13'h24},{4'd8,13'h25},{4'd8,13'h58},
    {4'd8,13'h59},{4'd8,13'h5A},{4'd8,13'h5B},{4'd8,13'h4A},
    {4'd8,13'h4B},{4'd8,13'h32},{4'd8,13'h33},{4'd8,13'h34}
  };

  localparam mh_code_t BLACK_TERM [0:63] = '{
    {4'd10,13'h37},{4'd3,13'h2},{4'd2,13'h3},{4'd2,13'h2},
    {4'd3,13'h3},{4'd4,13'h3},{4'd4,13'h2},{4'd5,13'h3},
    {4'd6,13'h5},{4'd6,13'h4},{4'd7,13'h4},{4'd7,13'h5},
    {4'd7,13'h7},{4'd8,13'h4},{4'd8,13'h7},{4'd9,13'h18},
    {4'd10,13'h17},{4'd10,13'h18},{4'd10,13'h08},{4'd11,13'h67},
    {4'd11,13'h68},{4'd11,13'h6C},{4'd11,13'h37},{4'd11,13'h28},
    {4'd11,13'h17},{4'd11,13'h18},{4'd12,13'hCA},{4'd12,13'hCB},
    {4'd12,13'hCC},{4'd12,13'hCD},{4'd12,13'h68},{4'd12,13'h69},
    {4'd12,13'h6A},{4'd12,13'h6B},{4'd12,13'hD2},{4'd12,13'hD3},
    {4'd12,13'hD4},{4'd12,13'hD5},{4'd12,13'hD6},{4'd12,13'hD7},
    {4'd12,13'h6C},{4'd12,13'h6D},{4'd12,13'hDA},{4'd12,13'hDB},
    {4'd12,13'h54},{4'd12,13'h55},{4'd12,13'h56},{4'd12,13'h57},
    {4'd12,13'h64},{4'd12,13'h65},{4'd12,13'h52},{4'd12,13'h53},
    {4'd12,13'h24},{4'd12,13'h37},{4'd12,13'h38},{4'd12,13'h27},
    {4'd12,13'h28},{4'd12,13'h58},{4'd12,13'h59},{4'd12,13'h2B},
    {4'd12,13'h2C},{4'd12,13'h5A},{4'd12,13'h66},{4'd12,13'h67}
  };

  localparam mh_code_t WHITE_MAKEUP [0:26] = '{
    {4'd5,13'h1B},{4'd5,13'h12},{4'd6,13'h17},{4'd7,13'h37},
    {4'd8,13'h36},{4'd8,13'h37},{4'd8,13'h64},{4'd8,13'h65},
    {4'd8,13'h68},{4'd8,13'h67},{4'd9,13'hCC},{4'd9,13'hCD},
    {4'd9,13'hD2},{4'd9,13'hD3},{4'd9,13'hD4},{4'd9,13'hD5},
    {4'd9,13'hD6},{4'd9,13'hD7},{4'd9,13'hD8},{4'd9,13'hD9},
    {4'd9,13'hDA},{4'd9,13'hDB},{4'd9,13'h98},{4'd9,13'h99},
    {4'd9,13'h9A},{4'd6,13'h18},{4'd9,13'h9B}
  };

  localparam mh_code_t BLACK_MAKEUP [0:26] = '{
    {4'd10,13'h0F},{4'd12,13'hC8},{4'd12,13'hC9},{4'd12,13'h5B},
    {4'd12,13'h33},{4'd12,13'h34},{4'd12,13'h35},{4'd13,13'h6C},
    {4'd13,13'h6D},{4'd13,13'h4A},{4'd13,13'h4B},{4'd13,13'h4C},
    {4'd13,13'h4D},{4'd13,13'h72},{4'd13,13'h73},{4'd13,13'h74},
    {4'd13,13'h75},{4'd13,13'h76},{4'd13,13'h77},{4'd13,13'h52},
    {4'd13,13'h53},{4'd13,13'h54},{4'd13,13'h55},{4'd13,13'h5A},
    {4'd13,13'h5B},{4'd13,13'h64},{4'd13,13'h65}
  };

endpackage

>>> rtl/core/g3fax_front.sv
module g3fax_front #(
  parameter int MAX_WIDTH = 1728
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  g3fax_pkg::in_word_t in_data,
  output logic                in_stall,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [10:0]         cfg_wdata,
  output logic                q_push,
  output g3fax_pkg::job_t     q_job,
  input  logic                q_full
);
  import g3fax_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam logic [CW-1:0] MW = CW'(MAX_WIDTH);

  logic [7:0]    thr_r;
  logic [10:0]   lw_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] rn_r, rn_nxt;
  logic          rc_r, rc_nxt, rf_r, rf_nxt, df_r, df_nxt;

  // pending jobs of the item in hand
  logic          eol0_r, eol0_nxt;
  logic          a_v_r, a_v_nxt, a_blk_r, a_blk_nxt, a_first_r, a_first_nxt;
  logic [CW-1:0] a_len_r, a_len_nxt;
  logic          b_v_r, b_v_nxt, b_blk_r, b_blk_nxt, b_first_r, b_first_nxt;
  logic [CW-1:0] b_len_r, b_len_nxt;
  logic          c_v_r, c_v_nxt;
  logic [CW-1:0] c_len_r, c_len_nxt;
  logic          eol1_r, eol1_nxt;
  logic [2:0]    doc_r, doc_nxt;
  logic          flush_r, flush_nxt;

  logic          busy, accept;
  logic [CW-1:0] w, pad;
  logic [9:0]    sum, thr3;
  logic          blk;

  assign busy = eol0_r | a_v_r | b_v_r | c_v_r | eol1_r | (doc_r != 3'd0) | flush_r;
  assign in_stall = busy;
  assign accept = in_valid & ~busy;

  // classify the incoming word and plan its jobs
  always_comb begin
    if (lw_r > 11'(MAX_WIDTH)) begin
      w = MW;
    end else if (lw_r == 11'd0) begin
      w = CW'(1);
    end else begin
      w = CW'(lw_r);
    end
    sum  = {2'b0, in_data.red} + {2'b0, in_data.green} + {2'b0, in_data.blue};
    thr3 = {2'b0, thr_r} + {1'b0, thr_r, 1'b0};
    blk  = (sum < thr3);
    pad  = '0;

    col_nxt = (col_r > w) ? w : col_r;
    rn_nxt = rn_r;
    rc_nxt = rc_r;
    rf_nxt = rf_r;
    df_nxt = df_r;
    eol0_nxt = 1'b0;
    a_v_nxt = 1'b0; a_len_nxt = rn_r; a_blk_nxt = rc_r; a_first_nxt = rf_r;
    b_v_nxt = 1'b0; b_len_nxt = '0; b_blk_nxt = 1'b0; b_first_nxt = 1'b0;
    c_v_nxt = 1'b0; c_len_nxt = '0;
    eol1_nxt = 1'b0;
    doc_nxt = 3'd0;
    flush_nxt = 1'b0;

    if (in_data.op) begin
      doc_nxt = DOC_EOLS;
      flush_nxt = 1'b1;
      col_nxt = '0;
      rn_nxt = '0;
      rc_nxt = 1'b0;
      rf_nxt = 1'b1;
      df_nxt = 1'b1;
    end else begin
      if (col_nxt < w) begin
        if (col_nxt == '0) begin
          eol0_nxt = df_r;
          df_nxt = 1'b0;
          rc_nxt = blk;
          rn_nxt = CW'(1);
          rf_nxt = 1'b1;
        end else if (blk == rc_r) begin
          rn_nxt = rn_r + CW'(1);
        end else begin
          a_v_nxt = 1'b1;
          rf_nxt = 1'b0;
          rc_nxt = blk;
          rn_nxt = CW'(1);
        end
        col_nxt = col_nxt + CW'(1);
      end
      if (in_data.row_end && (col_nxt != '0)) begin
        pad = w - col_nxt;
        b_v_nxt = 1'b1;
        b_blk_nxt = rc_nxt;
        b_first_nxt = rf_nxt;
        if (!rc_nxt) begin
          b_len_nxt = rn_nxt + pad;
        end else begin
          b_len_nxt = rn_nxt;
          c_v_nxt = (pad != '0);
          c_len_nxt = pad;
        end
        rf_nxt = 1'b0;
        eol1_nxt = 1'b1;
        col_nxt = '0;
        rn_nxt = '0;
      end
    end
  end

  // hand out one job per cycle while the queue is not full, in stream order
  always_comb begin
    q_job = '0;
    q_job.kind = J_EOL;
    if (eol0_r) begin
      q_job.eoi = ~(a_v_r | b_v_r | c_v_r | eol1_r);
    end else if (a_v_r) begin
      q_job.kind = J_RUN;
      q_job.len = LEN_W'(a_len_r);
      q_job.black = a_blk_r;
      q_job.first = a_first_r;
      q_job.eoi = ~(b_v_r | c_v_r | eol1_r);
    end else if (b_v_r) begin
      q_job.kind = J_RUN;
      q_job.len = LEN_W'(b_len_r);
      q_job.black = b_blk_r;
      q_job.first = b_first_r;
      q_job.eoi = ~(c_v_r | eol1_r);
    end else if (c_v_r) begin
      q_job.kind = J_RUN;
      q_job.len = LEN_W'(c_len_r);
      q_job.eoi = ~eol1_r;
    end else if (eol1_r) begin
      q_job.eoi = 1'b1;
    end else if (doc_r != 3'd0) begin
      q_job.eoi = 1'b0;
    end else begin
      q_job.kind = J_FLUSH;
      q_job.eoi = 1'b1;
      q_job.doc = 1'b1;
    end
  end

  assign q_push = busy & ~q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 8'd200;
      lw_r <= 11'd1728;
      col_r <= '0;
      rn_r <= '0;
      rc_r <= 1'b0;
      rf_r <= 1'b1;
      df_r <= 1'b1;
      eol0_r <= 1'b0;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      eol1_r <= 1'b0;
      doc_r <= 3'd0;
      flush_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DARK_THRESHOLD: thr_r <= cfg_wdata[7:0];
          REG_LINE_WIDTH:     lw_r <= cfg_wdata;
          default:            thr_r <= thr_r;
        endcase
      end
      if (accept) begin
        col_r <= col_nxt;
        rn_r <= rn_nxt;
        rc_r <= rc_nxt;
        rf_r <= rf_nxt;
        df_r <= df_nxt;
        eol0_r <= eol0_nxt;
        a_v_r <= a_v_nxt;
        b_v_r <= b_v_nxt;
        c_v_r <= c_v_nxt;
        eol1_r <= eol1_nxt;
        doc_r <= doc_nxt;
        flush_r <= flush_nxt;
      end else if (q_push) begin
        if (eol0_r) begin
          eol0_r <= 1'b0;
        end else if (a_v_r) begin
          a_v_r <= 1'b0;
        end else if (b_v_r) begin
          b_v_r <= 1'b0;
        end else if (c_v_r) begin
          c_v_r <= 1'b0;
        end else if (eol1_r) begin
          eol1_r <= 1'b0;
        end else if (doc_r != 3'd0) begin
          doc_r <= doc_r - 3'd1;
        end else begin
          flush_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_len_r <= a_len_nxt;
      a_blk_r <= a_blk_nxt;
      a_first_r <= a_first_nxt;
      b_len_r <= b_len_nxt;
      b_blk_r <= b_blk_nxt;
      b_first_r <= b_first_nxt;
      c_len_r <= c_len_nxt;
    end
  end

endmodule

>>> rtl/core/g3fax_queue.sv
module g3fax_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  g3fax_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output g3fax_pkg::job_t pop_job,
  output logic            empty
);
  import g3fax_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t          mem_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full = (cnt_r == (PW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign pop_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop && !empty) begin
        rp_r <= rp_r + PW'(1);
      end
      cnt_r <= cnt_r + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= push_job;
    end
  end

endmodule

>>> rtl/core/g3fax_back.sv
module g3fax_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  g3fax_pkg::job_t      q_job,
  output logic                 q_pop,
  output logic                 out_valid,
  output g3fax_pkg::out_word_t out_data,
  input  logic                 out_stall
);
  import g3fax_pkg::*;

  typedef enum logic [1:0] {
    PH_W0,
    PH_MK,
    PH_TERM,
    PH_END
  } phase_t;

  logic      cur_v_r;
  job_t      cur_r;
  phase_t    ph_r;
  logic [23:0] acc_r;
  logic [4:0]  cnt_r;
  logic        pend_v_r;
  logic [7:0]  pend_r;
  logic        out_v_r;
  out_word_t   out_r;

  logic        out_free, byte_rdy, has_mk;
  logic [4:0]  mk_idx;
  mh_code_t    ent;
  logic [4:0]  sh;
  logic [23:0] acc_app;
  phase_t      ph_start;

  assign out_valid = out_v_r;
  assign out_data = out_r;
  assign out_free = ~out_v_r | ~out_stall;
  assign byte_rdy = (cnt_r >= 5'd8);
  assign q_pop = ~byte_rdy & ~cur_v_r & ~q_empty;

  always_comb begin
    mk_idx = cur_r.len[10:6] - 5'd1;
    if (mk_idx > 5'd26) begin
      mk_idx = 5'd26;
    end
    has_mk = (cur_r.len >= LEN_W'(64));
    case (ph_r)
      PH_W0:   ent = WHITE_TERM[0];
      PH_MK:   ent = cur_r.black ? BLACK_MAKEUP[mk_idx] : WHITE_MAKEUP[mk_idx];
      default: begin
        if (cur_r.kind == J_EOL) begin
          ent = EOL_CODE;
        end else begin
          ent = cur_r.black ? BLACK_TERM[cur_r.len[5:0]] : WHITE_TERM[cur_r.len[5:0]];
        end
      end
    endcase
    // codes go in MSB-aligned behind the bits already held
    sh = 5'd24 - cnt_r - {1'b0, ent[16:13]};
    acc_app = acc_r | ({11'b0, ent[12:0]} << sh);
    if (q_job.kind == J_RUN && q_job.black && q_job.first) begin
      ph_start = PH_W0;
    end else if (q_job.kind == J_RUN && q_job.len >= LEN_W'(64)) begin
      ph_start = PH_MK;
    end else begin
      ph_start = PH_TERM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      ph_r <= PH_END;
      acc_r <= '0;
      cnt_r <= '0;
      pend_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
      if (byte_rdy) begin
        // a full byte waits in pend until we know whether another follows
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_v_r <= 1'b1;
            out_r <= '{out_byte: pend_r, last_of_item: 1'b0, doc_done: 1'b0};
          end
          pend_r <= acc_r[23:16];
          pend_v_r <= 1'b1;
          acc_r <= {acc_r[15:0], 8'b0};
          cnt_r <= cnt_r - 5'd8;
        end
      end else if (cur_v_r) begin
        case (ph_r)
          PH_W0: begin
            acc_r <= acc_app;
            cnt_r <= cnt_r + {1'b0, ent[16:13]};
            ph_r <= has_mk ? PH_MK : PH_TERM;
          end
          PH_MK: begin
            acc_r <= acc_app;
            cnt_r <= cnt_r + {1'b0, ent[16:13]};
            ph_r <= PH_TERM;
          end
          PH_TERM: begin
            if (cur_r.kind == J_FLUSH) begin
              if (cnt_r != 5'd0) begin
                cnt_r <= 5'd8;
              end
            end else begin
              acc_r <= acc_app;
              cnt_r <= cnt_r + {1'b0, ent[16:13]};
            end
            ph_r <= PH_END;
          end
          default: begin
            if (cur_r.eoi && pend_v_r) begin
              if (out_free) begin
                out_v_r <= 1'b1;
                out_r <= '{out_byte: pend_r, last_of_item: 1'b1, doc_done: cur_r.doc};
                pend_v_r <= 1'b0;
                cur_v_r <= 1'b0;
              end
            end else begin
              cur_v_r <= 1'b0;
            end
          end
        endcase
      end else if (q_pop) begin
        cur_v_r <= 1'b1;
        cur_r <= q_job;
        ph_r <= ph_start;
      end
    end
  end

endmodule

>>> rtl/core/g3_fax_line_encoder.sv
// channel | ports                          | moves
// --------+--------------------------------+-------------------------------------
// in      | in_valid, in_stall, in_data    | one pixel or end-of-document word
// out     | out_valid, out_stall, out_data | one byte of the coded bit stream
// cfg     | cfg_we, cfg_index, cfg_wdata   | dark threshold / line width write
//
// a pixel word that closes no run is taken without a stall; a word that closes
// runs holds the input until its queued jobs (up to four) are handed out, longer
// while the queue is full; an end-of-document word holds it for its seven jobs
// the back end takes a job, appends its codes one at a time, shifts out each
// full byte and closes the job at its end, so the byte rate is set by the single
// code packer after the job queue
// end of document queues six eols and a flush, and all run state clears
// reset is synchronous; both sides stall independently across the queue
module g3_fax_line_encoder #(
  parameter int MAX_WIDTH = 1728
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  g3fax_pkg::in_word_t  in_data,
  output logic                 in_stall,
  output logic                 out_valid,
  output g3fax_pkg::out_word_t out_data,
  input  logic                 out_stall,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [10:0]          cfg_wdata
);
  import g3fax_pkg::*;

  // jobs between classifier and code packer
  logic q_push, q_full, q_pop, q_empty;
  job_t q_in_job, q_out_job;

  // front: color decision, run tracking, row padding, job planning
  g3fax_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_job     (q_in_job),
    .q_full    (q_full)
  );

  // short job queue absorbs code bursts at run ends
  g3fax_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_out_job),
    .empty    (q_empty)
  );

  // back: huffman lookup, msb-first byte packing, last-byte marking
  g3fax_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_out_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

>>> rtl/core/g3fax_checker.sv
`include "g3_fax_line_encoder_assert.svh"

module g3fax_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input g3fax_pkg::in_word_t  in_data,
  input logic                 in_stall,
  input logic                 out_valid,
  input g3fax_pkg::out_word_t out_data,
  input logic                 out_stall
);

  `G3F_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `G3F_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  `G3F_ASSERT_NOW(a_doc_last, out_valid && out_data.doc_done, out_data.last_of_item)
  `G3F_ASSERT_NEXT(a_doc_busy, in_valid && !in_stall && in_data.op, in_stall)

endmodule

bind g3_fax_line_encoder g3fax_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_data   (in_data),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_data  (out_data),
  .out_stall (out_stall)
);
